/* src/eftt_pkg.sv */
`timescale 1ns / 1ps

package eftt_pkg;

    localparam int NUM_ENCODERS_DEF = 2;

    localparam logic [7:0]  CODE_COUNT_READ = 8'h31;
    localparam logic [15:0] THRESHOLD_RESET = 16'd52428;
    localparam logic [15:0] INVERT_RESET    = 16'd1;
    localparam logic [17:0] COUNT_SPAN      = 18'd65536;
    localparam logic [3:0]  LEN_FORMAT_A    = 4'd5;
    localparam logic [3:0]  LEN_FORMAT_B    = 4'd4;

    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK    = 1'd1;

    typedef enum logic [1:0] {
        KIND_FRAME  = 2'd0,
        KIND_POLL   = 2'd1,
        KIND_UPDATE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_REJECTED = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_NO_FRESH = 3'd3,
        ST_POLL     = 3'd4,
        ST_BAD_ID   = 3'd5
    } t_status;

    typedef struct packed {
        logic [3:0] frame_length;
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic [7:0] ext_id_byte;
        logic [7:0] unit_id;
    } t_frame;

    typedef struct packed {
        logic        fresh;
        logic        invert;
        logic [15:0] latest;
        logic [15:0] previous;
        logic [31:0] total;
        logic [15:0] turns;
    } t_entry;

    typedef struct packed {
        logic        store;
        logic        consume;
        logic        clear_all;
        logic [7:0]  addr;
        logic [15:0] count;
        logic [31:0] total;
        logic [15:0] turns;
    } t_upd;

    typedef struct packed {
        t_status     status;
        logic [7:0]  addr;
        logic [15:0] count;
        logic [16:0] delta;
        logic [31:0] total;
        logic [15:0] turns;
    } t_result;

endpackage

/* src/eftt_core.sv */
`timescale 1ns / 1ps

module eftt_core #(
    parameter int NUM_ENCODERS = eftt_pkg::NUM_ENCODERS_DEF
) (
    input  eftt_pkg::t_kind   i_kind,
    input  eftt_pkg::t_frame  i_frame,
    input  logic [15:0]       i_wrap_threshold,
    input  eftt_pkg::t_entry  i_entry,
    output logic [7:0]        o_sel_addr,
    output eftt_pkg::t_upd    o_upd,
    output eftt_pkg::t_result o_result
);

    logic              fmt_a;
    logic              fmt_b;
    logic [7:0]        frame_addr;
    logic [15:0]       frame_count;
    logic              frame_addr_ok;
    logic              id_ok;
    logic signed [17:0] diff_raw;
    logic signed [17:0] diff_inv;
    logic signed [17:0] diff_fix;
    logic signed [17:0] thr;
    logic [15:0]       turns_fix;

    always_comb begin
        fmt_a = (i_frame.frame_length >= eftt_pkg::LEN_FORMAT_A)
                && (i_frame.byte_one == eftt_pkg::CODE_COUNT_READ);
        fmt_b = (i_frame.frame_length >= eftt_pkg::LEN_FORMAT_B)
                && (i_frame.byte_zero == eftt_pkg::CODE_COUNT_READ);
        if (fmt_a) begin
            frame_addr  = i_frame.byte_zero;
            frame_count = {i_frame.byte_two, i_frame.byte_three};
        end else begin
            frame_addr  = i_frame.ext_id_byte;
            frame_count = {i_frame.byte_one, i_frame.byte_two};
        end
        frame_addr_ok = (fmt_a || fmt_b) && (frame_addr != 8'd0)
                        && (frame_addr <= 8'(NUM_ENCODERS));
        id_ok = (i_frame.unit_id != 8'd0)
                && (i_frame.unit_id <= 8'(NUM_ENCODERS));
        o_sel_addr = (i_kind == eftt_pkg::KIND_FRAME) ? frame_addr : i_frame.unit_id;
    end

    always_comb begin
        thr      = signed'({2'b00, i_wrap_threshold});
        diff_raw = signed'({2'b00, i_entry.latest}) - signed'({2'b00, i_entry.previous});
        diff_inv = i_entry.invert ? -diff_raw : diff_raw;
        priority if (diff_inv > thr) begin
            diff_fix  = diff_inv - signed'(eftt_pkg::COUNT_SPAN);
            turns_fix = i_entry.turns - 16'd1;
        end else if (diff_inv < -thr) begin
            diff_fix  = diff_inv + signed'(eftt_pkg::COUNT_SPAN);
            turns_fix = i_entry.turns + 16'd1;
        end else begin
            diff_fix  = diff_inv;
            turns_fix = i_entry.turns;
        end
    end

    always_comb begin
        o_upd           = '0;
        o_upd.addr      = o_sel_addr;
        o_result        = '0;
        o_result.status = eftt_pkg::ST_REJECTED;
        unique case (i_kind)
            eftt_pkg::KIND_FRAME: begin
                if (frame_addr_ok) begin
                    o_upd.store     = 1'b1;
                    o_upd.count     = frame_count;
                    o_result.status = eftt_pkg::ST_STORED;
                    o_result.addr   = frame_addr;
                    o_result.count  = frame_count;
                    o_result.total  = i_entry.total;
                    o_result.turns  = i_entry.turns;
                end
            end
            eftt_pkg::KIND_POLL: begin
                o_upd.clear_all = 1'b1;
                o_result.status = eftt_pkg::ST_POLL;
            end
            eftt_pkg::KIND_UPDATE: begin
                if (!id_ok) begin
                    o_result.status = eftt_pkg::ST_BAD_ID;
                end else if (!i_entry.fresh) begin
                    o_result.status = eftt_pkg::ST_NO_FRESH;
                    o_result.addr   = i_frame.unit_id;
                    o_result.total  = i_entry.total;
                    o_result.turns  = i_entry.turns;
                end else begin
                    o_upd.consume   = 1'b1;
                    o_upd.count     = i_entry.latest;
                    o_upd.total     = i_entry.total + 32'(diff_fix);
                    o_upd.turns     = turns_fix;
                    o_result.status = eftt_pkg::ST_UPDATED;
                    o_result.addr   = i_frame.unit_id;
                    o_result.count  = i_entry.latest;
                    o_result.delta  = diff_fix[16:0];
                    o_result.total  = o_upd.total;
                    o_result.turns  = turns_fix;
                end
            end
            default: begin
                o_result.status = eftt_pkg::ST_REJECTED;
            end
        endcase
    end

endmodule

/* src/encoder_frame_turn_tracker.sv */
`timescale 1ns / 1ps

// Multi-turn tracker for a small set of absolute encoders read over a bus.
// Input channel s_axis: tuser carries the item kind (received frame, poll
// start, update one encoder); tdata carries the frame length, four frame
// bytes, the extended-ID byte and the encoder id. Output channel m_axis:
// tuser carries the status code, tdata the address, count, unwrapped delta,
// running total, turn count and the all-fresh flag.
// Configuration: i_cfg_wr_en with i_cfg_index 0 writes the wrap threshold,
// index 1 the invert mask; write only while no item is in flight.
// An accepted item is captured in the input register and then moves into the
// result register, which presents the result. Throughput is one item per
// cycle while the receiver does not stall m_axis; the per-encoder register
// file is read and written in the same cycle that an item moves from the
// input register to the result register, so the next item always sees the
// updated state.
// Reset (synchronous, active low) empties both registers, sets the threshold
// to 52428 and the invert mask to 1, and clears all counts, totals, turns and
// fresh marks. When m_axis_tready is low the result holds, one more item is
// taken only if the input register is empty, then s_axis_tready drops.

module encoder_frame_turn_tracker #(
    parameter int NUM_ENCODERS = eftt_pkg::NUM_ENCODERS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // frame_length, byte_zero, byte_one, byte_two, byte_three, ext_id_byte,
    // unit id, zero fill
    input  logic [eftt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind
    input  logic [eftt_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // address, count_value, delta, total, turns, all_fresh, zero fill
    output logic [eftt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status
    output logic [eftt_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    input  logic                                i_cfg_wr_en,
    input  logic [eftt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [eftt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

    logic [15:0] r_wrap_threshold;
    logic [15:0] r_invert_mask;

    logic              r_in_valid;
    eftt_pkg::t_kind   r_in_kind;
    eftt_pkg::t_frame  r_in_frame;

    logic              r_out_valid;
    eftt_pkg::t_result r_out_result;
    logic              r_out_all_fresh;

    logic [15:0] r_latest   [NUM_ENCODERS];
    logic [15:0] r_previous [NUM_ENCODERS];
    logic [31:0] r_total    [NUM_ENCODERS];
    logic [15:0] r_turns    [NUM_ENCODERS];
    logic [NUM_ENCODERS-1:0] r_fresh;
    logic [NUM_ENCODERS-1:0] n_fresh;

    logic              out_free;
    logic              advance;
    logic [7:0]        sel_addr;
    logic [7:0]        sel_addr_m1;
    logic [IDX_W-1:0]  sel_idx;
    eftt_pkg::t_entry  entry;
    eftt_pkg::t_upd    upd;
    eftt_pkg::t_result result;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_threshold <= eftt_pkg::THRESHOLD_RESET;
            r_invert_mask    <= eftt_pkg::INVERT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                eftt_pkg::REG_WRAP_THRESHOLD: r_wrap_threshold <= i_cfg_wdata;
                eftt_pkg::REG_INVERT_MASK:    r_invert_mask    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind  <= eftt_pkg::t_kind'(s_axis_tuser);
            r_in_frame <= eftt_pkg::t_frame'({s_axis_tdata[3:0], s_axis_tdata[11:4],
                                              s_axis_tdata[19:12], s_axis_tdata[27:20],
                                              s_axis_tdata[35:28], s_axis_tdata[43:36],
                                              s_axis_tdata[51:44]});
        end
    end

    assign sel_addr_m1 = sel_addr - 8'd1;
    assign sel_idx     = sel_addr_m1[IDX_W-1:0];

    always_comb begin
        entry.fresh    = r_fresh[sel_idx];
        entry.invert   = r_invert_mask[sel_idx];
        entry.latest   = r_latest[sel_idx];
        entry.previous = r_previous[sel_idx];
        entry.total    = r_total[sel_idx];
        entry.turns    = r_turns[sel_idx];
    end

    eftt_core #(
        .NUM_ENCODERS (NUM_ENCODERS)
    ) u_core (
        .i_kind           (r_in_kind),
        .i_frame          (r_in_frame),
        .i_wrap_threshold (r_wrap_threshold),
        .i_entry          (entry),
        .o_sel_addr       (sel_addr),
        .o_upd            (upd),
        .o_result         (result)
    );

    always_comb begin
        n_fresh = r_fresh;
        priority if (upd.clear_all) begin
            n_fresh = '0;
        end else if (upd.store) begin
            n_fresh[sel_idx] = 1'b1;
        end else if (upd.consume) begin
            n_fresh[sel_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= '0;
            for (int i = 0; i < NUM_ENCODERS; i++) begin
                r_latest[i]   <= '0;
                r_previous[i] <= '0;
                r_total[i]    <= '0;
                r_turns[i]    <= '0;
            end
        end else if (advance) begin
            r_fresh <= n_fresh;
            if (upd.store) begin
                r_latest[sel_idx] <= upd.count;
            end
            if (upd.consume) begin
                r_previous[sel_idx] <= upd.count;
                r_total[sel_idx]    <= upd.total;
                r_turns[sel_idx]    <= upd.turns;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_result    <= result;
            r_out_all_fresh <= &n_fresh;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_result.status;
    assign m_axis_tdata  = {6'd0, r_out_all_fresh, r_out_result.turns, r_out_result.total,
                            r_out_result.delta, r_out_result.count, r_out_result.addr};

endmodule

/* src/eftt_checker.sv */
`timescale 1ns / 1ps

module eftt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [eftt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [eftt_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    logic quiet_status;

    assign quiet_status = (m_axis_tuser == eftt_pkg::ST_REJECTED)
                          || (m_axis_tuser == eftt_pkg::ST_POLL)
                          || (m_axis_tuser == eftt_pkg::ST_BAD_ID);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled item changed");

    a_quiet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && quiet_status |-> m_axis_tdata[88:0] == '0)
        else $error("reject, poll or bad id item carries data");

    a_no_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == eftt_pkg::ST_NO_FRESH
        |-> m_axis_tdata[40:8] == '0 && m_axis_tdata[7:0] != 8'd0)
        else $error("no-fresh item with count or delta");

    a_delta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[40:24] != 17'h10000)
        else $error("unwrapped delta out of range");

endmodule

bind encoder_frame_turn_tracker eftt_checker u_eftt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
